// ===== hw/rtl/dti_pkg.sv =====
// Shared types, character codes and limits for the decimal text to int64 parser.
package dti_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_SYNTAX = 2'd1;
    localparam status_t ST_RANGE  = 2'd2;

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_TRAIL  = 5'b01000,
        PH_ENDED  = 5'b10000
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [63:0] MAG_LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_LIMIT_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_TENTH     = 64'h0CCC_CCCC_CCCC_CCCC;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } in_t;

    typedef struct packed {
        logic signed [63:0] value;
        status_t            status;
    } out_t;

    typedef struct packed {
        phase_t      phase;
        logic [63:0] magnitude;
        logic        is_negative;
        logic        first_nz;
        status_t     err;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:       PH_LEAD,
        magnitude:   64'd0,
        is_negative: 1'b0,
        first_nz:    1'b0,
        err:         ST_OK
    };

endpackage

// ===== hw/rtl/dti_parse.sv =====
// Next-state logic for one text byte of the parser.
module dti_parse (
    input  dti_pkg::parse_state_t st,
    input  logic [7:0]            ch,
    output dti_pkg::parse_state_t nxt
);

    logic        is_blank;
    logic        is_digit;
    logic        dig_fnz;
    logic [63:0] dig_limit;
    logic [63:0] mag_x10;
    dti_pkg::parse_state_t dig_st;

    assign is_blank = (ch == dti_pkg::CH_SPACE) ||
                      ((ch >= dti_pkg::CH_TAB) && (ch <= dti_pkg::CH_CR));
    assign is_digit = (ch >= dti_pkg::CH_ZERO) && (ch <= dti_pkg::CH_NINE);

    assign dig_fnz   = (st.phase != dti_pkg::PH_DIGITS) ? (ch[3:0] != 4'd0) : st.first_nz;
    assign dig_limit = (st.is_negative && dig_fnz) ? dti_pkg::MAG_LIMIT_NEG
                                                   : dti_pkg::MAG_LIMIT_POS;
    assign mag_x10   = {st.magnitude[60:0], 3'b000} + {st.magnitude[62:0], 1'b0}
                     + {60'd0, ch[3:0]};

    // accumulate one digit
    always_comb
    begin
        dig_st          = st;
        dig_st.first_nz = dig_fnz;
        dig_st.phase    = dti_pkg::PH_DIGITS;
        if (st.magnitude == dti_pkg::MAG_LIMIT_NEG)
        begin
            dig_st.err   = dti_pkg::ST_SYNTAX;
            dig_st.phase = dti_pkg::PH_ENDED;
        end
        else if (st.magnitude > dti_pkg::MAG_TENTH || mag_x10 > dig_limit)
        begin
            dig_st.err   = dti_pkg::ST_RANGE;
            dig_st.phase = dti_pkg::PH_ENDED;
        end
        else
        begin
            dig_st.magnitude = mag_x10;
        end
    end

    always_comb
    begin
        nxt = st;
        if (st.err == dti_pkg::ST_OK)
        begin
            if (ch == dti_pkg::CH_NUL)
            begin
                if (st.phase == dti_pkg::PH_LEAD || st.phase == dti_pkg::PH_SIGN)
                begin
                    nxt.err   = dti_pkg::ST_SYNTAX;
                    nxt.phase = dti_pkg::PH_ENDED;
                end
                else if (st.phase == dti_pkg::PH_DIGITS || st.phase == dti_pkg::PH_TRAIL)
                begin
                    nxt.phase = dti_pkg::PH_ENDED;
                end
            end
            else
            begin
                unique case (st.phase)
                    dti_pkg::PH_LEAD:
                    begin
                        if (is_blank)
                        begin
                            nxt = st;
                        end
                        else if (ch == dti_pkg::CH_MINUS)
                        begin
                            nxt.is_negative = 1'b1;
                            nxt.phase       = dti_pkg::PH_SIGN;
                        end
                        else if (ch == dti_pkg::CH_PLUS)
                        begin
                            nxt.phase = dti_pkg::PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            nxt = dig_st;
                        end
                        else
                        begin
                            nxt.err   = dti_pkg::ST_SYNTAX;
                            nxt.phase = dti_pkg::PH_ENDED;
                        end
                    end
                    dti_pkg::PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            nxt = dig_st;
                        end
                        else
                        begin
                            nxt.err   = dti_pkg::ST_SYNTAX;
                            nxt.phase = dti_pkg::PH_ENDED;
                        end
                    end
                    dti_pkg::PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            nxt = dig_st;
                        end
                        else if (is_blank)
                        begin
                            nxt.phase = dti_pkg::PH_TRAIL;
                        end
                        else
                        begin
                            nxt.err   = dti_pkg::ST_SYNTAX;
                            nxt.phase = dti_pkg::PH_ENDED;
                        end
                    end
                    dti_pkg::PH_TRAIL:
                    begin
                        if (!is_blank)
                        begin
                            nxt.err   = dti_pkg::ST_SYNTAX;
                            nxt.phase = dti_pkg::PH_ENDED;
                        end
                    end
                    default:
                    begin
                        nxt = st;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/decimal_text_to_int64_top.sv =====
// Top level of the streaming decimal text to signed 64-bit integer parser.
// The final byte is parsed from the input register; its result is registered for output.
// Throughput: one byte per cycle when not stalled; the parse state updates once per byte.
// A result waiting in the output register stalls the input only when the next final byte
// arrives; other bytes keep flowing.
// Reset: asynchronous, active low; clears the parse state and both valid flags.
module decimal_text_to_int64_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          char_valid,
    output logic          char_stall,
    input  dti_pkg::in_t  char_data,
    output logic          result_valid,
    input  logic          result_stall,
    output dti_pkg::out_t result_data
);

    typedef struct packed {
        dti_pkg::status_t status;
        logic             is_negative;
        logic [63:0]      magnitude;
    } res_t;

    dti_pkg::in_t          in_reg;
    logic                  in_valid_reg;
    dti_pkg::parse_state_t state_reg;
    dti_pkg::parse_state_t state_next;
    res_t                  res_reg;
    res_t                  res_next;
    logic                  res_valid_reg;
    logic                  out_free;
    logic                  adv;
    logic                  adv_last;
    logic                  load_in;

    dti_parse u_parse (
        .st  (state_reg),
        .ch  (in_reg.char_in),
        .nxt (state_next)
    );

    assign out_free   = !res_valid_reg || !result_stall;
    assign adv        = in_valid_reg && (!in_reg.last_char || out_free);
    assign adv_last   = adv && in_reg.last_char;
    assign char_stall = in_valid_reg && !adv;
    assign load_in    = char_valid && !char_stall;

    always_comb
    begin
        res_next.status      = state_next.err;
        res_next.is_negative = state_next.is_negative;
        res_next.magnitude   = state_next.magnitude;
        if (state_next.err == dti_pkg::ST_OK &&
            (state_next.phase == dti_pkg::PH_LEAD || state_next.phase == dti_pkg::PH_SIGN))
        begin
            res_next.status = dti_pkg::ST_SYNTAX;
        end
        if (res_next.status != dti_pkg::ST_OK)
        begin
            res_next.magnitude = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= dti_pkg::PARSE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                state_reg <= in_reg.last_char ? dti_pkg::PARSE_RESET : state_next;
            end
            if (adv_last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_reg <= char_data;
        end
        if (adv_last)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid       = res_valid_reg;
    assign result_data.status = res_reg.status;
    assign result_data.value  = res_reg.is_negative ? $signed(64'd0 - res_reg.magnitude)
                                                    : $signed(res_reg.magnitude);

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv_last |=> result_valid)
        else $error("final byte did not produce a result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.status == dti_pkg::ST_OK ||
                          result_data.status == dti_pkg::ST_SYNTAX ||
                          result_data.status == dti_pkg::ST_RANGE))
        else $error("result status outside its codes");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.status != dti_pkg::ST_OK) |-> result_data.value == 64'sd0)
        else $error("failed parse gave a nonzero value");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        adv_last |=> (state_reg.phase == dti_pkg::PH_LEAD && state_reg.err == dti_pkg::ST_OK &&
                      state_reg.magnitude == 64'd0))
        else $error("parse state not cleared after a string");

    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.err != dti_pkg::ST_OK |-> state_reg.phase == dti_pkg::PH_ENDED)
        else $error("error recorded without ending the string");
`endif

endmodule

// ===== test/tb_decimal_text_to_int64_top.sv =====
// Testbench for decimal_text_to_int64_top: directed and random texts checked by table or parse model.
`timescale 1ns / 100ps

module tb_decimal_text_to_int64_top;

    localparam int RANDOM_CHARS = 1500;
    localparam int QUIET_CHARS  = 300;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        string            text;
        bit               nul;
        string            tail;
        bit               typed;
        logic [63:0]      value;
        dti_pkg::status_t status;
    } text_case_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          char_valid;
    logic          char_stall;
    dti_pkg::in_t  char_data;
    logic          result_valid;
    logic          result_stall;
    dti_pkg::out_t result_data;

    dti_pkg::out_t parse_results_due[$];
    int   n_fail;
    bit   gaps_on;
    bit   hold_req;

    dti_pkg::phase_t  scan_phase;
    logic [63:0]      digit_mag;
    logic             neg_sign;
    logic             lead_nz;
    dti_pkg::status_t sticky_err;

    text_case_t text_cases [25] = '{
        '{"0",                     1'b0, "", 1'b1, 64'd0, dti_pkg::ST_OK},
        '{"9223372036854775807",   1'b0, "", 1'b1, dti_pkg::MAG_LIMIT_POS, dti_pkg::ST_OK},
        '{"-9223372036854775808",  1'b0, "", 1'b1, dti_pkg::MAG_LIMIT_NEG, dti_pkg::ST_OK},
        '{"9223372036854775808",   1'b0, "", 1'b1, 64'd0, dti_pkg::ST_RANGE},
        '{"-9223372036854775809",  1'b0, "", 1'b1, 64'd0, dti_pkg::ST_RANGE},
        '{"-92233720368547758080", 1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"-09223372036854775808", 1'b0, "", 1'b1, 64'd0, dti_pkg::ST_RANGE},
        '{"+9223372036854775808",  1'b0, "", 1'b1, 64'd0, dti_pkg::ST_RANGE},
        '{"99999999999999999999",  1'b0, "", 1'b1, 64'd0, dti_pkg::ST_RANGE},
        '{"99999999999999999999x", 1'b0, "", 1'b1, 64'd0, dti_pkg::ST_RANGE},
        '{"x99999999999999999999", 1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"",                      1'b1, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"  \011\012\013\014\015", 1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"-",                     1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"+",                     1'b1, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"1a",                    1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"1 2",                   1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"- 5",                   1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"+-5",                   1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"\377",                  1'b0, "", 1'b1, 64'd0, dti_pkg::ST_SYNTAX},
        '{"\011\012\013\014\015 +42 \011", 1'b0, "", 1'b0, 64'd0, dti_pkg::ST_OK},
        '{"12",                    1'b1, "x9\377", 1'b0, 64'd0, dti_pkg::ST_OK},
        '{"12",                    1'b1, "", 1'b0, 64'd0, dti_pkg::ST_OK},
        '{"007",                   1'b0, "", 1'b0, 64'd0, dti_pkg::ST_OK},
        '{"-17 ",                  1'b1, "5", 1'b0, 64'd0, dti_pkg::ST_OK}
    };

    decimal_text_to_int64_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == dti_pkg::CH_SPACE || (c >= dti_pkg::CH_TAB && c <= dti_pkg::CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= dti_pkg::CH_ZERO && c <= dti_pkg::CH_NINE;
    endfunction

    function automatic void clear_parser();
        scan_phase = dti_pkg::PH_LEAD;
        digit_mag  = 64'd0;
        neg_sign   = 1'b0;
        lead_nz    = 1'b0;
        sticky_err = dti_pkg::ST_OK;
    endfunction

    function automatic void note_error(input dti_pkg::status_t kind);
        if (sticky_err == dti_pkg::ST_OK)
            sticky_err = kind;
        scan_phase = dti_pkg::PH_ENDED;
    endfunction

    function automatic void absorb_digit(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] lim;
        logic [63:0] nxt;
        d = 64'(c - dti_pkg::CH_ZERO);
        if (scan_phase != dti_pkg::PH_DIGITS)
        begin
            lead_nz    = (d != 64'd0);
            scan_phase = dti_pkg::PH_DIGITS;
        end
        if (digit_mag == dti_pkg::MAG_LIMIT_NEG)
            note_error(dti_pkg::ST_SYNTAX);
        else if (digit_mag > dti_pkg::MAG_TENTH)
            note_error(dti_pkg::ST_RANGE);
        else
        begin
            lim = (neg_sign && lead_nz) ? dti_pkg::MAG_LIMIT_NEG : dti_pkg::MAG_LIMIT_POS;
            nxt = digit_mag * 64'd10 + d;
            if (nxt > lim)
                note_error(dti_pkg::ST_RANGE);
            else
                digit_mag = nxt;
        end
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input logic fin,
                                      output dti_pkg::out_t res);
        dti_pkg::status_t st;
        res = '0;
        if (scan_phase != dti_pkg::PH_ENDED && sticky_err == dti_pkg::ST_OK)
        begin
            if (c == dti_pkg::CH_NUL)
            begin
                if (scan_phase == dti_pkg::PH_LEAD || scan_phase == dti_pkg::PH_SIGN)
                    note_error(dti_pkg::ST_SYNTAX);
                else
                    scan_phase = dti_pkg::PH_ENDED;
            end
            else
            begin
                case (scan_phase)
                    dti_pkg::PH_LEAD:
                    begin
                        if (!is_blank(c))
                        begin
                            if (c == dti_pkg::CH_MINUS)
                            begin
                                neg_sign   = 1'b1;
                                scan_phase = dti_pkg::PH_SIGN;
                            end
                            else if (c == dti_pkg::CH_PLUS)
                                scan_phase = dti_pkg::PH_SIGN;
                            else if (is_digit(c))
                                absorb_digit(c);
                            else
                                note_error(dti_pkg::ST_SYNTAX);
                        end
                    end
                    dti_pkg::PH_SIGN:
                    begin
                        if (is_digit(c))
                            absorb_digit(c);
                        else
                            note_error(dti_pkg::ST_SYNTAX);
                    end
                    dti_pkg::PH_DIGITS:
                    begin
                        if (is_digit(c))
                            absorb_digit(c);
                        else if (is_blank(c))
                            scan_phase = dti_pkg::PH_TRAIL;
                        else
                            note_error(dti_pkg::ST_SYNTAX);
                    end
                    default:
                    begin
                        if (!is_blank(c))
                            note_error(dti_pkg::ST_SYNTAX);
                    end
                endcase
            end
        end
        if (!fin)
            return 1'b0;
        st = sticky_err;
        if (st == dti_pkg::ST_OK &&
            (scan_phase == dti_pkg::PH_LEAD || scan_phase == dti_pkg::PH_SIGN))
            st = dti_pkg::ST_SYNTAX;
        res.status = st;
        if (st == dti_pkg::ST_OK)
            res.value = neg_sign ? (64'd0 - digit_mag) : digit_mag;
        clear_parser();
        return 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic fin,
                             input bit typed, input dti_pkg::out_t typed_res);
        int            gap;
        dti_pkg::out_t res;
        gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{char_in: ch, last_char: fin};
        do
        begin
            @(posedge clk);
        end
        while (char_stall);
        if (parse_char(ch, fin, res))
            parse_results_due.push_back(typed ? typed_res : res);
    endtask

    task automatic send_text(input logic [7:0] s[$], input bit typed,
                             input dti_pkg::out_t typed_res);
        for (int i = 0; i < s.size(); i++)
            send_char(s[i], i == s.size() - 1, typed, typed_res);
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? dti_pkg::CH_SPACE : 8'(dti_pkg::CH_TAB + k - 1);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(dti_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic void build_number_text(ref logic [7:0] s[$]);
        string near_limit;
        int    mode;
        int    nd;
        near_limit = "922337203685477580";
        s.delete();
        if ($urandom_range(0, 15) == 0)
        begin
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) s.push_back(pick_blank());
        case ($urandom_range(0, 2))
            1: s.push_back(dti_pkg::CH_MINUS);
            2: s.push_back(dti_pkg::CH_PLUS);
            default: ;
        endcase
        mode = $urandom_range(0, 9);
        if (mode <= 7)
        begin
            nd = (mode <= 5) ? $urandom_range(1, 12) : $urandom_range(17, 21);
            repeat (nd) s.push_back(pick_digit());
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                s.push_back(dti_pkg::CH_ZERO);
            for (int i = 0; i < near_limit.len(); i++)
                s.push_back(near_limit[i]);
            s.push_back(8'(dti_pkg::CH_ZERO + $urandom_range(6, 9)));
            if ($urandom_range(0, 2) == 0)
                s.push_back(pick_digit());
        end
        repeat ($urandom_range(0, 2)) s.push_back(pick_blank());
        if ($urandom_range(0, 5) == 0)
        begin
            s.push_back(dti_pkg::CH_NUL);
            repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0)
            s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                result_stall <= 1'b0;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        dti_pkg::out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (parse_results_due.size() == 0)
            begin
                $error("unexpected transaction: value %0d status %0d",
                       result_data.value, result_data.status);
                n_fail++;
            end
            else
            begin
                want = parse_results_due.pop_front();
                if (result_data.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, result_data.value);
                    n_fail++;
                end
                if (result_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result_data.status);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [7:0]    chars[$];
        dti_pkg::out_t typed_res;
        int            sent;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_data  = '0;
        n_fail     = 0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        clear_parser();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (text_cases[r])
        begin
            chars.delete();
            for (int i = 0; i < text_cases[r].text.len(); i++)
                chars.push_back(text_cases[r].text[i]);
            if (text_cases[r].nul)
                chars.push_back(dti_pkg::CH_NUL);
            for (int i = 0; i < text_cases[r].tail.len(); i++)
                chars.push_back(text_cases[r].tail[i]);
            typed_res.value  = text_cases[r].value;
            typed_res.status = text_cases[r].status;
            send_text(chars, text_cases[r].typed, typed_res);
        end

        hold_req = 1'b1;
        sent     = 0;
        while (sent < RANDOM_CHARS)
        begin
            gaps_on = (sent < RANDOM_CHARS - QUIET_CHARS);
            build_number_text(chars);
            send_text(chars, 1'b0, typed_res);
            sent += chars.size();
        end
        @(negedge clk);
        char_valid <= 1'b0;

        while (parse_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
